// ===== design/cfb_pkg.sv =====
// Package for the command frame builder: channel payload types, queue job type,
// frame constants and output step codes. No dependencies.
package cfb_pkg;

	// Frame type bytes and checksum seed
	localparam logic [7:0] TYPE_CMD  = 8'hA0;
	localparam logic [7:0] TYPE_TLS  = 8'hB0;
	localparam logic [7:0] BODY_SEED = 8'hAA;

	// Frame kinds
	localparam logic KIND_CMD = 1'b0;
	localparam logic KIND_TLS = 1'b1;

	// Job queue between front and back
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// Output step codes, in emission order within one job
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_TYPE    = 4'd0;
	localparam logic [STEP_W-1:0] STEP_LEN_LO  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_LEN_HI  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_HDR_SUM = 4'd3;
	localparam logic [STEP_W-1:0] STEP_CMD     = 4'd4;
	localparam logic [STEP_W-1:0] STEP_PLEN_LO = 4'd5;
	localparam logic [STEP_W-1:0] STEP_PLEN_HI = 4'd6;
	localparam logic [STEP_W-1:0] STEP_DATA    = 4'd7;
	localparam logic [STEP_W-1:0] STEP_CHECK   = 4'd8;
	localparam logic [STEP_W-1:0] STEP_NONE    = 4'd9;

	typedef struct packed {
		logic        frame_kind;
		logic [7:0]  command_code;
		logic [15:0] payload_length;
		logic [7:0]  data_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
	} out_t;

	// One classified input transaction: which byte groups to emit and their values
	typedef struct packed {
		logic       has_hdr;
		logic       kind;
		logic [7:0] len_lo;
		logic [7:0] len_hi;
		logic [7:0] hdr_sum;
		logic       hdr_end;
		logic [7:0] cmd;
		logic [7:0] plen_lo;
		logic [7:0] plen_hi;
		logic       has_data;
		logic [7:0] data;
		logic       data_end;
		logic       has_chk;
		logic [7:0] check;
	} job_t;

endpackage

// ===== design/command_frame_builder_unit.sv =====
// Command frame builder top level: front end, job queue and back end.
// Each accepted item passes through the job queue and then the output register.
// Throughput: one output byte per cycle while output is taken; a payload item gives
// one byte (two on the last byte of a command frame), a frame's first item 4 to 9 bytes.
// Input is taken every cycle while the 4-entry job queue has room.
// Reset (arst_n low, asynchronous) closes any open frame and empties queue and output.
module command_frame_builder_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cfb_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output cfb_pkg::out_t out_data
);

	cfb_pkg::job_t push_job;
	cfb_pkg::job_t head_job;
	logic          push;
	logic          pop;
	logic          q_empty;
	logic          q_full;

	cfb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.job      (push_job)
	);

	cfb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (push_job),
		.pop    (pop),
		.head   (head_job),
		.empty  (q_empty),
		.full   (q_full)
	);

	cfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head_job),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== design/cfb_front.sv =====
// Front end of the command frame builder: accepts input transactions, tracks the
// open frame and turns each transaction into a job for the queue. Uses cfb_pkg.
module cfb_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cfb_pkg::in_t  in_data,
	input  logic          q_full,
	output logic          push,
	output cfb_pkg::job_t job
);

	logic        in_frame_q;
	logic        kind_held_q;
	logic [15:0] bytes_left_q;
	logic [7:0]  body_sum_q;

	logic        kind_eff;
	logic [7:0]  type_byte;
	logic [15:0] len;
	logic [15:0] plen;
	logic [7:0]  base_sum;
	logic [7:0]  run_sum;
	logic [15:0] left_base;
	logic [15:0] left_next;
	logic        empty_frame;
	logic        last_byte;

	assign in_ready = ~q_full;
	assign push     = in_valid & in_ready;

	// Classify the transaction and work out header fields and sums
	always_comb begin
		kind_eff    = in_frame_q ? kind_held_q : in_data.frame_kind;
		type_byte   = in_data.frame_kind ? cfb_pkg::TYPE_TLS : cfb_pkg::TYPE_CMD;
		len         = in_data.frame_kind ? in_data.payload_length
		                                 : in_data.payload_length + 16'd4;
		plen        = in_data.payload_length + 16'd1;
		empty_frame = ~in_frame_q & (in_data.payload_length == 16'd0);
		if (in_frame_q) begin
			base_sum  = body_sum_q;
			left_base = bytes_left_q;
		end else begin
			base_sum  = in_data.frame_kind ? 8'd0
			            : in_data.command_code + plen[7:0] + plen[15:8];
			left_base = in_data.payload_length;
		end
		run_sum   = empty_frame ? base_sum : base_sum + in_data.data_byte;
		left_next = left_base - 16'd1;
		last_byte = ~empty_frame & (left_next == 16'd0);

		job          = '0;
		job.has_hdr  = ~in_frame_q;
		job.kind     = kind_eff;
		job.len_lo   = len[7:0];
		job.len_hi   = len[15:8];
		job.hdr_sum  = type_byte + len[7:0] + len[15:8];
		job.hdr_end  = empty_frame & (in_data.frame_kind == cfb_pkg::KIND_TLS);
		job.cmd      = in_data.command_code;
		job.plen_lo  = plen[7:0];
		job.plen_hi  = plen[15:8];
		job.has_data = ~empty_frame;
		job.data     = in_data.data_byte;
		job.data_end = last_byte & (kind_eff == cfb_pkg::KIND_TLS);
		job.has_chk  = (empty_frame | last_byte) & (kind_eff == cfb_pkg::KIND_CMD);
		job.check    = cfb_pkg::BODY_SEED - run_sum;
	end

	// Advance the open-frame state on every accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			kind_held_q  <= 1'b0;
			bytes_left_q <= '0;
			body_sum_q   <= '0;
		end else if (push) begin
			kind_held_q  <= kind_eff;
			body_sum_q   <= run_sum;
			if (empty_frame) begin
				in_frame_q   <= 1'b0;
				bytes_left_q <= '0;
			end else begin
				in_frame_q   <= ~last_byte;
				bytes_left_q <= left_next;
			end
		end
	end

	// An open frame always has payload bytes outstanding
	a_open_has_left: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (bytes_left_q != 16'd0))
		else $error("open frame with no bytes left");

endmodule

// ===== design/cfb_queue.sv =====
// Short job queue between front and back of the command frame builder, held in
// flip-flops with one write and one read pointer. Uses cfb_pkg.
module cfb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cfb_pkg::job_t wr_job,
	input  logic          pop,
	output cfb_pkg::job_t head,
	output logic          empty,
	output logic          full
);

	cfb_pkg::job_t                 entry_q [cfb_pkg::QDEPTH];
	logic [cfb_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [cfb_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [cfb_pkg::QCNT_W-1:0]    count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == cfb_pkg::QCNT_W'(cfb_pkg::QDEPTH));
	assign head  = entry_q[rd_ptr_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full job queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty job queue");

endmodule

// ===== design/cfb_back.sv =====
// Back end of the command frame builder: walks the head job byte by byte and
// drives the registered output channel. Uses cfb_pkg.
module cfb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  cfb_pkg::job_t head,
	input  logic          empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output cfb_pkg::out_t out_data
);

	logic [cfb_pkg::STEP_W-1:0] step_q;
	logic [cfb_pkg::STEP_W-1:0] cur_step;
	logic [cfb_pkg::STEP_W-1:0] nxt_step;
	logic                       out_valid_q;
	cfb_pkg::out_t              out_data_q;
	cfb_pkg::out_t              sel;
	logic                       load;

	// First step present in the job at or after the given one
	function automatic logic [cfb_pkg::STEP_W-1:0] pick(cfb_pkg::job_t j,
	                                                    logic [cfb_pkg::STEP_W-1:0] from);
		logic [8:0]                 mask;
		logic [cfb_pkg::STEP_W-1:0] r;
		mask = {j.has_chk, j.has_data, {3{j.has_hdr & (j.kind == cfb_pkg::KIND_CMD)}},
		        {4{j.has_hdr}}};
		r = cfb_pkg::STEP_NONE;
		for (int i = 8; i >= 0; i--) begin
			if (mask[i] && (cfb_pkg::STEP_W'(i) >= from)) begin
				r = cfb_pkg::STEP_W'(i);
			end
		end
		return r;
	endfunction

	// Choose the byte for the current step
	always_comb begin
		cur_step = pick(head, step_q);
		nxt_step = pick(head, cur_step + 1'b1);
		load     = ~empty & (~out_valid_q | out_ready);
		pop      = load & (nxt_step == cfb_pkg::STEP_NONE);
		sel      = '0;
		case (cur_step)
			cfb_pkg::STEP_TYPE:    sel.out_byte = (head.kind == cfb_pkg::KIND_TLS) ?
			                                      cfb_pkg::TYPE_TLS : cfb_pkg::TYPE_CMD;
			cfb_pkg::STEP_LEN_LO:  sel.out_byte = head.len_lo;
			cfb_pkg::STEP_LEN_HI:  sel.out_byte = head.len_hi;
			cfb_pkg::STEP_HDR_SUM: begin
				sel.out_byte  = head.hdr_sum;
				sel.frame_end = head.hdr_end;
			end
			cfb_pkg::STEP_CMD:     sel.out_byte = head.cmd;
			cfb_pkg::STEP_PLEN_LO: sel.out_byte = head.plen_lo;
			cfb_pkg::STEP_PLEN_HI: sel.out_byte = head.plen_hi;
			cfb_pkg::STEP_DATA: begin
				sel.out_byte  = head.data;
				sel.frame_end = head.data_end;
			end
			cfb_pkg::STEP_CHECK: begin
				sel.out_byte  = head.check;
				sel.frame_end = 1'b1;
			end
			default:               sel = '0;
		endcase
	end

	// Hold the output byte until taken
	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= sel;
		end
	end

	// Advance step and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= cfb_pkg::STEP_TYPE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q      <= pop ? cfb_pkg::STEP_TYPE : nxt_step;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A job is retired only when its last byte moves into the output register
	a_pop_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("job retired without loading a byte");

endmodule
